// File: hdl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // fixed field widths of the stream words
    localparam int REQ_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int CROW_W  = 5;
    localparam int CCOL_W  = 7;
    localparam int POS_W   = 11;

    // packed word widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    // attribute used by the clearing pass after reset
    localparam logic [BYTE_W-1:0] RESET_COLOR = 8'h07;

    // special characters of the stream
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_STREAM    = 3'd0,
        REQ_READ      = 3'd1,
        REQ_WR_CHAR   = 3'd2,
        REQ_WR_COLOR  = 3'd3,
        REQ_CLEAR     = 3'd4
    } t_req;

    // store access controls
    typedef struct packed {
        logic we_char;
        logic we_color;
        logic re;
    } t_mem_ctl;

    // result word from the sequencer
    typedef struct packed {
        logic              valid;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] rchar;
        logic [BYTE_W-1:0] rcolor;
    } t_res;

endpackage

// File: hdl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text console over a ROWS x COLUMNS store of character and colour bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per word (kind in tuser); m_axis returns one
//   result word per request: cursor position and, for a read, the cell bytes.
//   i_cfg_we / i_cfg_wdata set the default colour; write it only when idle.
// Sequence from accept to next accept:
//   plain character, CR, LF, cell write: S_IDLE, then S_RESP; cell read: S_RDW between them;
//   tab: S_TAB writes the spaces (one store write per space);
//   a scroll adds a sweep that blanks one row (rows rotate, no copy);
//   clear: a sweep over all ROWS*COLUMNS cells, one cell per cycle through the store port.
//   The result is loaded into the output register from S_RESP, after any
//   tab spaces or blanking sweep.
// Reset: cursor home; a clearing pass writes NUL and colour 7 to every
//   cell, s_axis_tready stays low meanwhile.
// Stall: the output register holds the result while m_axis_tready is low;
//   one further request is taken and then waits for the register to drain.
// ----------------------------------------------------------------------------
module text_console_cursor_engine #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] data_byte, [12:8] cell_row, [19:13] cell_col, [23:20] zero
    input  logic [tcce_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [2:0] req_type
    input  logic [tcce_pkg::REQ_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [10:0] cursor_position, [18:11] read_char, [26:19] read_color, [31:27] zero
    output logic [tcce_pkg::M_DATA_W-1:0] m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [tcce_pkg::BYTE_W-1:0]   i_cfg_wdata
);
    import tcce_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic [BYTE_W-1:0] r_def_color;
    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_pos;
    logic [BYTE_W-1:0] r_out_char;
    logic [BYTE_W-1:0] r_out_color;

    t_res              res;
    t_mem_ctl          mem_ctl;
    logic              res_take;
    logic [AW-1:0]     mem_addr;
    logic [BYTE_W-1:0] mem_wchar;
    logic [BYTE_W-1:0] mem_wcolor;
    logic [BYTE_W-1:0] mem_rchar;
    logic [BYTE_W-1:0] mem_rcolor;

    // default colour register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_color <= RESET_COLOR;
        end else if (i_cfg_we) begin
            r_def_color <= i_cfg_wdata;
        end
    end

    // output register
    assign res_take = res.valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_pos   <= res.pos;
            r_out_char  <= res.rchar;
            r_out_color <= res.rcolor;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_DATA_W - POS_W - 2 * BYTE_W)'(0),
                            r_out_color, r_out_char, r_out_pos};

    tcce_ctrl #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP),
        .CELLS    (CELLS),
        .AW       (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_req       (t_req'(s_axis_tuser)),
        .i_data      (s_axis_tdata[BYTE_W-1:0]),
        .i_cell_row  (s_axis_tdata[BYTE_W+CROW_W-1:BYTE_W]),
        .i_cell_col  (s_axis_tdata[BYTE_W+CROW_W+CCOL_W-1:BYTE_W+CROW_W]),
        .i_def_color (r_def_color),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_mem       (mem_ctl),
        .o_addr      (mem_addr),
        .o_wchar     (mem_wchar),
        .o_wcolor    (mem_wcolor),
        .i_rchar     (mem_rchar),
        .i_rcolor    (mem_rcolor)
    );

    tcce_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_ctl    (mem_ctl),
        .i_addr   (mem_addr),
        .i_wchar  (mem_wchar),
        .i_wcolor (mem_wcolor),
        .o_rchar  (mem_rchar),
        .o_rcolor (mem_rcolor)
    );

endmodule

// File: hdl/tcce_mem.sv
// ----------------------------------------------------------------------------
// tcce_mem
// Character and colour stores, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tcce_mem #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                        i_clk,
    input  tcce_pkg::t_mem_ctl          i_ctl,
    input  logic [AW-1:0]               i_addr,
    input  logic [tcce_pkg::BYTE_W-1:0] i_wchar,
    input  logic [tcce_pkg::BYTE_W-1:0] i_wcolor,
    output logic [tcce_pkg::BYTE_W-1:0] o_rchar,
    output logic [tcce_pkg::BYTE_W-1:0] o_rcolor
);
    import tcce_pkg::*;

    logic [BYTE_W-1:0] r_chars  [DEPTH];
    logic [BYTE_W-1:0] r_colors [DEPTH];
    logic [BYTE_W-1:0] r_rchar;
    logic [BYTE_W-1:0] r_rcolor;

    // character store
    always_ff @(posedge i_clk) begin
        if (i_ctl.we_char) begin
            r_chars[i_addr] <= i_wchar;
        end
        if (i_ctl.re) begin
            r_rchar <= r_chars[i_addr];
        end
    end

    // colour store
    always_ff @(posedge i_clk) begin
        if (i_ctl.we_color) begin
            r_colors[i_addr] <= i_wcolor;
        end
        if (i_ctl.re) begin
            r_rcolor <= r_colors[i_addr];
        end
    end

    assign o_rchar  = r_rchar;
    assign o_rcolor = r_rcolor;

endmodule

// File: hdl/tcce_ctrl.sv
// ----------------------------------------------------------------------------
// tcce_ctrl
// Request sequencer: cursor, row rotation, tab expansion, sweeps and reads.
// ----------------------------------------------------------------------------
module tcce_ctrl #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4,
    parameter int CELLS    = ROWS * COLUMNS,
    parameter int AW       = $clog2(CELLS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tcce_pkg::t_req              i_req,
    input  logic [tcce_pkg::BYTE_W-1:0] i_data,
    input  logic [tcce_pkg::CROW_W-1:0] i_cell_row,
    input  logic [tcce_pkg::CCOL_W-1:0] i_cell_col,
    input  logic [tcce_pkg::BYTE_W-1:0] i_def_color,
    output tcce_pkg::t_res              o_res,
    input  logic                        i_res_take,
    output tcce_pkg::t_mem_ctl          o_mem,
    output logic [AW-1:0]               o_addr,
    output logic [tcce_pkg::BYTE_W-1:0] o_wchar,
    output logic [tcce_pkg::BYTE_W-1:0] o_wcolor,
    input  logic [tcce_pkg::BYTE_W-1:0] i_rchar,
    input  logic [tcce_pkg::BYTE_W-1:0] i_rcolor
);
    import tcce_pkg::*;

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = $clog2(COLUMNS);
    localparam int TPW   = $clog2(TAB_STOP);
    localparam int TLW   = $clog2(TAB_STOP + 1);

    typedef enum logic [4:0] {
        S_SWEEP = 5'b00001,
        S_IDLE  = 5'b00010,
        S_TAB   = 5'b00100,
        S_RDW   = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    t_state            r_state,  n_state;
    logic [COL_W-1:0]  r_col,    n_col;
    logic [ROW_W-1:0]  r_row,    n_row;
    logic [ROW_W-1:0]  r_top,    n_top;
    logic [TPW-1:0]    r_tph,    n_tph;
    logic [TLW-1:0]    r_tab,    n_tab;
    logic [AW-1:0]     r_sweep,  n_sweep;
    logic [AW-1:0]     r_send,   n_send;
    logic [AW-1:0]     r_base,   n_base;
    logic [BYTE_W-1:0] r_fill,   n_fill;
    logic              r_sresp,  n_sresp;
    logic [BYTE_W-1:0] r_rchar,  n_rchar;
    logic [BYTE_W-1:0] r_rcolor, n_rcolor;

    // logical row plus rotation, folded back into the store
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] a,
                                                  input logic [ROW_W-1:0] b);
        logic [ROW_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (ROW_W+1)'(ROWS)) begin
            s = s - (ROW_W+1)'(ROWS);
        end
        return s[ROW_W-1:0];
    endfunction

    logic             cell_ok;
    logic [ROW_W-1:0] cell_prow;
    logic [ROW_W-1:0] cur_prow;
    logic [AW-1:0]    cell_addr;
    logic [AW-1:0]    cur_addr;
    logic [AW-1:0]    top_base;
    logic [ROW_W-1:0] top_inc;
    logic             col_wrap;
    logic             row_last;
    logic             pp_scroll;
    logic [COL_W-1:0] pp_col;
    logic [ROW_W-1:0] pp_row;
    logic [TPW-1:0]   pp_tph;

    // addresses of the requested cell and of the cursor cell
    always_comb begin
        cell_ok   = (32'(i_cell_row) < 32'(ROWS)) && (32'(i_cell_col) < 32'(COLUMNS));
        cell_prow = phys_row(ROW_W'(i_cell_row), r_top);
        cur_prow  = phys_row(r_row, r_top);
        cell_addr = AW'(32'(cell_prow) * COLUMNS + 32'(COL_W'(i_cell_col)));
        cur_addr  = AW'(32'(cur_prow) * COLUMNS + 32'(r_col));
        top_base  = AW'(32'(r_top) * COLUMNS);
        top_inc   = (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + 1'b1;
    end

    // cursor after one plain character
    always_comb begin
        col_wrap  = (r_col == COL_W'(COLUMNS - 1));
        row_last  = (r_row == ROW_W'(ROWS - 1));
        pp_scroll = col_wrap && row_last;
        pp_col    = col_wrap ? '0 : r_col + 1'b1;
        pp_row    = (col_wrap && !row_last) ? r_row + 1'b1 : r_row;
        if (col_wrap || r_tph == TPW'(TAB_STOP - 1)) begin
            pp_tph = '0;
        end else begin
            pp_tph = r_tph + 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_row    = r_row;
        n_top    = r_top;
        n_tph    = r_tph;
        n_tab    = r_tab;
        n_sweep  = r_sweep;
        n_send   = r_send;
        n_base   = r_base;
        n_fill   = r_fill;
        n_sresp  = r_sresp;
        n_rchar  = r_rchar;
        n_rcolor = r_rcolor;
        o_mem    = '0;
        o_addr   = cur_addr;
        o_wchar  = i_data;
        o_wcolor = i_data;

        unique case (r_state)
            S_SWEEP: begin
                o_mem.we_char  = 1'b1;
                o_mem.we_color = 1'b1;
                o_addr         = r_base + r_sweep;
                o_wchar        = CH_NUL;
                o_wcolor       = r_fill;
                n_sweep        = r_sweep + 1'b1;
                if (r_sweep == r_send) begin
                    if (r_tab != '0) begin
                        n_state = S_TAB;
                    end else if (r_sresp) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rchar  = '0;
                    n_rcolor = '0;
                    n_state  = S_RESP;
                    unique case (i_req)
                        REQ_STREAM: begin
                            if (i_data == CH_LF) begin
                                n_col = '0;
                                n_tph = '0;
                                if (row_last) begin
                                    n_top   = top_inc;
                                    n_base  = top_base;
                                    n_sweep = '0;
                                    n_send  = AW'(COLUMNS - 1);
                                    n_fill  = i_def_color;
                                    n_sresp = 1'b1;
                                    n_tab   = '0;
                                    n_state = S_SWEEP;
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end else if (i_data == CH_CR) begin
                                n_col = '0;
                                n_tph = '0;
                            end else if (i_data == CH_TAB) begin
                                n_tab   = TLW'(TAB_STOP) - TLW'(r_tph);
                                n_state = S_TAB;
                            end else begin
                                o_mem.we_char = 1'b1;
                                n_col = pp_col;
                                n_row = pp_row;
                                n_tph = pp_tph;
                                if (pp_scroll) begin
                                    n_top   = top_inc;
                                    n_base  = top_base;
                                    n_sweep = '0;
                                    n_send  = AW'(COLUMNS - 1);
                                    n_fill  = i_def_color;
                                    n_sresp = 1'b1;
                                    n_tab   = '0;
                                    n_state = S_SWEEP;
                                end
                            end
                        end
                        REQ_READ: begin
                            o_addr = cell_addr;
                            if (cell_ok) begin
                                o_mem.re = 1'b1;
                                n_state  = S_RDW;
                            end
                        end
                        REQ_WR_CHAR: begin
                            o_addr        = cell_addr;
                            o_mem.we_char = cell_ok;
                        end
                        REQ_WR_COLOR: begin
                            o_addr         = cell_addr;
                            o_mem.we_color = cell_ok;
                        end
                        REQ_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_top   = '0;
                            n_tph   = '0;
                            n_tab   = '0;
                            n_base  = '0;
                            n_sweep = '0;
                            n_send  = AW'(CELLS - 1);
                            n_fill  = i_def_color;
                            n_sresp = 1'b1;
                            n_state = S_SWEEP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TAB: begin
                // one space per cycle at the cursor, paused for the sweep when a space scrolls
                o_mem.we_char = 1'b1;
                o_wchar       = CH_SPACE;
                n_col         = pp_col;
                n_row         = pp_row;
                n_tph         = pp_tph;
                n_tab         = r_tab - 1'b1;
                if (pp_scroll) begin
                    n_top   = top_inc;
                    n_base  = top_base;
                    n_sweep = '0;
                    n_send  = AW'(COLUMNS - 1);
                    n_fill  = i_def_color;
                    n_sresp = 1'b1;
                    n_state = S_SWEEP;
                end else if (r_tab == TLW'(1)) begin
                    n_state = S_RESP;
                end
            end
            S_RDW: begin
                n_rchar  = i_rchar;
                n_rcolor = i_rcolor;
                n_state  = S_RESP;
            end
            S_RESP: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_col   <= '0;
            r_row   <= '0;
            r_top   <= '0;
            r_tph   <= '0;
            r_tab   <= '0;
            r_sweep <= '0;
            r_send  <= AW'(CELLS - 1);
            r_base  <= '0;
            r_fill  <= RESET_COLOR;
            r_sresp <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_top   <= n_top;
            r_tph   <= n_tph;
            r_tab   <= n_tab;
            r_sweep <= n_sweep;
            r_send  <= n_send;
            r_base  <= n_base;
            r_fill  <= n_fill;
            r_sresp <= n_sresp;
        end
    end

    // read result bytes
    always_ff @(posedge i_clk) begin
        r_rchar  <= n_rchar;
        r_rcolor <= n_rcolor;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_res.valid  = (r_state == S_RESP);
    assign o_res.pos    = POS_W'(32'(r_row) * COLUMNS + 32'(r_col));
    assign o_res.rchar  = r_rchar;
    assign o_res.rcolor = r_rcolor;

endmodule
